// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the hsv to rgb conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HUE_W  = 9;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned REM_W  = 6;
  localparam int unsigned PN_W   = 16;
  localparam int unsigned SR_W   = 14;
  localparam int unsigned PROD_W = 22;
  localparam int unsigned RCP_W  = 23;
  localparam int unsigned RCP_SH = 36;
  localparam int unsigned QM_W   = PROD_W + RCP_W;

  localparam logic [CH_W-1:0]   FULL        = 8'd255;
  localparam logic [REM_W-1:0]  SECTOR_DEG  = 6'd60;
  localparam logic [SR_W-1:0]   FULL_SECTOR = 14'd15300;
  // ceil(2^36 / 15300), exact floor quotient for products up to 255 * 15300
  localparam logic [RCP_W-1:0]  SECTOR_RCP  = 23'd4491470;

  typedef enum logic [2:0] {
    SEC_RY,
    SEC_YG,
    SEC_GC,
    SEC_CB,
    SEC_BM,
    SEC_MR,
    SEC_BLACK
  } sector_t;

  typedef struct packed {
    sector_t          sector;
    logic [REM_W-1:0] rem;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } s1_t;

  typedef struct packed {
    sector_t         sector;
    logic [CH_W-1:0] val;
    logic [PN_W-1:0] pn;
    logic [SR_W-1:0] sr;
    logic [SR_W-1:0] st;
  } s2_t;

  typedef struct packed {
    sector_t           sector;
    logic [CH_W-1:0]   val;
    logic [CH_W-1:0]   p;
    logic [PROD_W-1:0] qx;
    logic [PROD_W-1:0] tx;
  } s3_t;

  typedef struct packed {
    sector_t         sector;
    logic [CH_W-1:0] val;
    logic [CH_W-1:0] p;
    logic [CH_W-1:0] q;
    logic [CH_W-1:0] t;
  } s4_t;

endpackage

// ===== rtl/hsv2rgb_sector.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Stage 1: splits the hue into a sector and the remainder within it.
// ----------------------------------------------------------------------------
module hsv2rgb_sector import hsv2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [HUE_W-1:0] hue,
  input  logic [CH_W-1:0]  sat,
  input  logic [CH_W-1:0]  val,
  input  logic             dn_ready,
  output logic             dn_valid,
  output s1_t              dn_data
);

  logic             valid_r;
  s1_t              data_r;
  s1_t              data_nxt;
  logic [HUE_W-1:0] base;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    priority if (hue >= 9'd360) begin
      data_nxt.sector = SEC_BLACK;
      base            = 9'd0;
    end else if (hue >= 9'd300) begin
      data_nxt.sector = SEC_MR;
      base            = 9'd300;
    end else if (hue >= 9'd240) begin
      data_nxt.sector = SEC_BM;
      base            = 9'd240;
    end else if (hue >= 9'd180) begin
      data_nxt.sector = SEC_CB;
      base            = 9'd180;
    end else if (hue >= 9'd120) begin
      data_nxt.sector = SEC_GC;
      base            = 9'd120;
    end else if (hue >= 9'd60) begin
      data_nxt.sector = SEC_YG;
      base            = 9'd60;
    end else begin
      data_nxt.sector = SEC_RY;
      base            = 9'd0;
    end
    // black ignores the remainder, so its width overflow does not matter
    data_nxt.rem = REM_W'(hue - base);
    data_nxt.sat = sat;
    data_nxt.val = val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/hsv2rgb_mult.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_mult
// Stages 2 and 3: the saturation products, then the brightness products
// and the p helper.
// ----------------------------------------------------------------------------
module hsv2rgb_mult import hsv2rgb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  s1_t  up_data,
  input  logic dn_ready,
  output logic dn_valid,
  output s3_t  dn_data,
  output logic mid_valid
);

  logic            s2_valid_r;
  s2_t             s2_r;
  s2_t             s2_nxt;
  logic            s2_ready;
  logic            s3_valid_r;
  s3_t             s3_r;
  s3_t             s3_nxt;
  logic            s3_ready;
  logic [CH_W-1:0] p_est;
  logic [PN_W:0]   p_rem;

  assign s3_ready = !s3_valid_r || dn_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign up_ready = s2_ready;

  always_comb begin
    s2_nxt.sector = up_data.sector;
    s2_nxt.val    = up_data.val;
    s2_nxt.pn     = PN_W'(up_data.val) * PN_W'(FULL - up_data.sat);
    s2_nxt.sr     = SR_W'(up_data.sat) * SR_W'(up_data.rem);
    s2_nxt.st     = SR_W'(up_data.sat) * SR_W'(SECTOR_DEG - up_data.rem);
  end

  // x / 255: x >> 8 is low by at most one, fix it with the remainder
  always_comb begin
    p_est = s2_r.pn[PN_W-1:CH_W];
    p_rem = {1'b0, s2_r.pn} - {1'b0, p_est, {CH_W{1'b0}}} + (PN_W+1)'(p_est);
    s3_nxt.sector = s2_r.sector;
    s3_nxt.val    = s2_r.val;
    s3_nxt.p      = (p_rem >= (PN_W+1)'(FULL)) ? p_est + 1'b1 : p_est;
    s3_nxt.qx     = PROD_W'(s2_r.val) * PROD_W'(FULL_SECTOR - s2_r.sr);
    s3_nxt.tx     = PROD_W'(s2_r.val) * PROD_W'(FULL_SECTOR - s2_r.st);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= up_valid;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && up_valid) begin
      s2_r <= s2_nxt;
    end
    if (s3_ready && s2_valid_r) begin
      s3_r <= s3_nxt;
    end
  end

  assign dn_valid  = s3_valid_r;
  assign dn_data   = s3_r;
  assign mid_valid = s2_valid_r;

endmodule

// ===== rtl/hsv2rgb_scale.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Stage 4: divides the q and t products by 15300 through a reciprocal.
// ----------------------------------------------------------------------------
module hsv2rgb_scale import hsv2rgb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  s3_t  up_data,
  input  logic dn_ready,
  output logic dn_valid,
  output s4_t  dn_data
);

  logic            valid_r;
  s4_t             data_r;
  s4_t             data_nxt;
  logic [QM_W-1:0] q_mul;
  logic [QM_W-1:0] t_mul;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    q_mul = QM_W'(up_data.qx) * QM_W'(SECTOR_RCP);
    t_mul = QM_W'(up_data.tx) * QM_W'(SECTOR_RCP);
    data_nxt.sector = up_data.sector;
    data_nxt.val    = up_data.val;
    data_nxt.p      = up_data.p;
    data_nxt.q      = q_mul[RCP_SH +: CH_W];
    data_nxt.t      = t_mul[RCP_SH +: CH_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/hsv2rgb_mux.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_mux
// Stage 5: routes v, p, q and t to red, green and blue by sector.
// ----------------------------------------------------------------------------
module hsv2rgb_mux import hsv2rgb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  s4_t             up_data,
  input  logic            dn_ready,
  output logic            dn_valid,
  output logic [CH_W-1:0] red,
  output logic [CH_W-1:0] green,
  output logic [CH_W-1:0] blue
);

  logic            valid_r;
  logic [CH_W-1:0] red_r;
  logic [CH_W-1:0] green_r;
  logic [CH_W-1:0] blue_r;
  logic [CH_W-1:0] red_nxt;
  logic [CH_W-1:0] green_nxt;
  logic [CH_W-1:0] blue_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    unique case (up_data.sector)
      SEC_RY: begin
        red_nxt = up_data.val; green_nxt = up_data.t;   blue_nxt = up_data.p;
      end
      SEC_YG: begin
        red_nxt = up_data.q;   green_nxt = up_data.val; blue_nxt = up_data.p;
      end
      SEC_GC: begin
        red_nxt = up_data.p;   green_nxt = up_data.val; blue_nxt = up_data.t;
      end
      SEC_CB: begin
        red_nxt = up_data.p;   green_nxt = up_data.q;   blue_nxt = up_data.val;
      end
      SEC_BM: begin
        red_nxt = up_data.t;   green_nxt = up_data.p;   blue_nxt = up_data.val;
      end
      SEC_MR: begin
        red_nxt = up_data.val; green_nxt = up_data.p;   blue_nxt = up_data.q;
      end
      default: begin
        red_nxt = '0;          green_nxt = '0;          blue_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign red      = red_r;
  assign green    = green_r;
  assign blue     = blue_r;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Six-sector hsv to 8-bit rgb conversion, five register stages.
//
//   channel   direction  handshake            word
//   in_       input      in_valid / in_stall   hue, saturation, brightness
//   out_      output     out_valid / out_stall red, green, blue
//
// one word accepted per cycle while in_stall is low; the stages, in order,
// are sector split, saturation products, brightness products, reciprocal
// scale and channel select
// each stage holds its word while the next one is full, so a stall fills
// the pipeline before in_stall rises
// synchronous active-low reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [HUE_W-1:0] in_hue,
  input  logic [CH_W-1:0]  in_saturation,
  input  logic [CH_W-1:0]  in_brightness,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue
);

  logic s1_ready;
  logic s1_valid;
  s1_t  s1_data;
  logic s2_valid;
  logic s23_ready;
  logic s3_valid;
  s3_t  s3_data;
  logic s4_ready;
  logic s4_valid;
  s4_t  s4_data;
  logic s5_ready;

  assign in_stall = !s1_ready;

  hsv2rgb_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (s1_ready),
    .hue      (in_hue),
    .sat      (in_saturation),
    .val      (in_brightness),
    .dn_ready (s23_ready),
    .dn_valid (s1_valid),
    .dn_data  (s1_data)
  );

  hsv2rgb_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s1_valid),
    .up_ready  (s23_ready),
    .up_data   (s1_data),
    .dn_ready  (s4_ready),
    .dn_valid  (s3_valid),
    .dn_data   (s3_data),
    .mid_valid (s2_valid)
  );

  hsv2rgb_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s4_ready),
    .up_data  (s3_data),
    .dn_ready (s5_ready),
    .dn_valid (s4_valid),
    .dn_data  (s4_data)
  );

  hsv2rgb_mux u_mux (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s4_valid),
    .up_ready (s5_ready),
    .up_data  (s4_data),
    .dn_ready (!out_stall),
    .dn_valid (out_valid),
    .red      (out_red),
    .green    (out_green),
    .blue     (out_blue)
  );

`ifndef NO_ASSERTIONS
  // an accepted word always lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted word did not enter stage 1");

  // backpressure only comes from the output side
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall)
    else $error("input stalled while output is free");

  // the input only stalls with every stage occupied
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && s2_valid && s3_valid && s4_valid && out_valid))
    else $error("input stalled with a bubble in the pipeline");

  a_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

// ===== dv/hsv_to_rgb_converter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker
// Watches both channels of the hsv to rgb converter. Each accepted hsv word
// is converted here to the rgb color it must produce; each accepted rgb word
// is compared field by field with the oldest color still owed.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_checker import hsv2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [HUE_W-1:0] in_hue,
  input  logic [CH_W-1:0]  in_saturation,
  input  logic [CH_W-1:0]  in_brightness,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [CH_W-1:0]  out_red,
  input  logic [CH_W-1:0]  out_green,
  input  logic [CH_W-1:0]  out_blue,
  output int               fail_count,
  output int               colors_owed
);

  localparam int unsigned DEG_PER_SECTOR = 60;
  localparam int unsigned UNIT           = 255;
  localparam int unsigned SECTOR_UNIT    = 15300;
  localparam int          MAX_PRINTS     = 40;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  rgb_t owed_colors[$];

  initial begin
    fail_count  = 0;
    colors_owed = 0;
  end

  function automatic rgb_t hsv_to_rgb(input logic [HUE_W-1:0] hue,
                                      input logic [CH_W-1:0] sat,
                                      input logic [CH_W-1:0] val);
    int unsigned h, s, v, frac, p, q, t;
    sector_t     sec;
    rgb_t        c;
    h    = hue;
    s    = sat;
    v    = val;
    frac = h % DEG_PER_SECTOR;
    // hue of 360 and up lands past the last sector: black
    sec  = (h / DEG_PER_SECTOR < 6) ? sector_t'(h / DEG_PER_SECTOR) : SEC_BLACK;
    p    = (v * (UNIT - s)) / UNIT;
    q    = (v * (SECTOR_UNIT - s * frac)) / SECTOR_UNIT;
    t    = (v * (SECTOR_UNIT - s * (DEG_PER_SECTOR - frac))) / SECTOR_UNIT;
    c    = '0;
    case (sec)
      SEC_RY: c = '{CH_W'(v), CH_W'(t), CH_W'(p)};
      SEC_YG: c = '{CH_W'(q), CH_W'(v), CH_W'(p)};
      SEC_GC: c = '{CH_W'(p), CH_W'(v), CH_W'(t)};
      SEC_CB: c = '{CH_W'(p), CH_W'(q), CH_W'(v)};
      SEC_BM: c = '{CH_W'(t), CH_W'(p), CH_W'(v)};
      SEC_MR: c = '{CH_W'(v), CH_W'(p), CH_W'(q)};
      default: c = '0;
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < MAX_PRINTS)
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (owed_colors.size() == 0) begin
          report_mismatch("rgb word with none owed, red", out_red, -1);
        end else begin
          want = owed_colors.pop_front();
          if (out_red !== want.red)
            report_mismatch("red", out_red, want.red);
          if (out_green !== want.green)
            report_mismatch("green", out_green, want.green);
          if (out_blue !== want.blue)
            report_mismatch("blue", out_blue, want.blue);
        end
      end
      if (in_valid && !in_stall)
        owed_colors.push_back(hsv_to_rgb(in_hue, in_saturation, in_brightness));
      colors_owed = owed_colors.size();
    end
  end

endmodule

// ===== dv/hsv_to_rgb_converter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Drives hsv words into the converter: sector edges and extremes first, then
// random colors under three idle mixes on both channels. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;
  import hsv2rgb_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int WORDS_PER_PHASE = 350;
  localparam int N_EDGE          = 24;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [HUE_W-1:0] in_hue;
  logic [CH_W-1:0]  in_saturation;
  logic [CH_W-1:0]  in_brightness;
  logic             out_valid;
  logic             out_stall;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;

  int fail_count;
  int colors_owed;
  int idle_pct;
  int stall_pct;
  int cycles;

  // hue, saturation, brightness at sector edges and field extremes
  int edge_hue[N_EDGE] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359,
                           360, 511, 30, 90, 150, 210, 270, 330, 45, 200, 256, 419};
  int edge_sat[N_EDGE] = '{255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255,
                           255, 255, 0, 128, 255, 1, 254, 170, 0, 255, 85, 255};
  int edge_val[N_EDGE] = '{255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255,
                           255, 255, 255, 0, 1, 200, 128, 254, 200, 0, 255, 255};

  hsv_to_rgb_converter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  hsv_to_rgb_converter_checker rgb_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .fail_count    (fail_count),
    .colors_owed   (colors_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** hsv_to_rgb_converter: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_hsv(input logic [HUE_W-1:0] hue, input logic [CH_W-1:0] sat,
                          input logic [CH_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // sender holds off until every owed color has come out
  task automatic drain_pipe();
    in_valid <= 1'b0;
    do @(negedge clk); while (colors_owed != 0);
  endtask

  initial begin
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
    cycles        = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_brightness = '0;
    out_stall     = 1'b0;
    idle_pct      = 25;
    stall_pct     = 82;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_EDGE; i++)
      push_hsv(HUE_W'(edge_hue[i]), CH_W'(edge_sat[i]), CH_W'(edge_val[i]));

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct  = (phase == 0) ? 25 : (phase == 1) ? 82 : 0;
      stall_pct = (phase == 0) ? 82 : (phase == 1) ? 25 : 0;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // mostly meaningful hues, some past 359 for black
        hue = ($urandom_range(99) < 85) ? HUE_W'($urandom_range(359))
                                        : HUE_W'($urandom_range(511, 360));
        sat = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                       : CH_W'($urandom_range(255));
        val = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                       : CH_W'($urandom_range(255));
        push_hsv(hue, sat, val);
      end
      drain_pipe();
    end

    // wait past the five-stage pipeline for stray words
    repeat (12) @(negedge clk);
    if (fail_count == 0 && colors_owed == 0) begin
      $display("** hsv_to_rgb_converter: PASSED **");
    end else begin
      $display("** hsv_to_rgb_converter: FAILED **");
    end
    $finish;
  end

endmodule
